// ===== rtl/danf_pkg.sv =====
package danf_pkg;

	// Widths of the item fields
	localparam int unsigned VAL_W  = 17;
	localparam int unsigned FRAC_W = 10;
	localparam int unsigned CHAR_W = 8;

	// Digit counter width, wide enough for the largest digit count (10)
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned DIG_CNT_W  = 4;

	// Queue between front and back
	localparam int unsigned Q_DEPTH = 2;

	// Parameter defaults
	localparam int unsigned INT_DIGITS_DEF  = 5;
	localparam int unsigned FRAC_DIGITS_DEF = 3;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_DOT  = 8'h2E;

	// Largest value the threshold compares need; anything above reads as all ones
	localparam longint unsigned SAT_LIM = (64'd1 << (VAL_W + 1)) - 64'd1;

	typedef struct packed {
		logic [VAL_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac_millis;
	} num_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              is_last;
	} chr_item_t;

	// Classified number handed from front to back
	typedef struct packed {
		logic [VAL_W-1:0]     int_val;
		logic [FRAC_W-1:0]    frac_val;
		logic [DIG_CNT_W-1:0] n_int;
		logic                 has_frac;
	} task_t;

	// k * 10^n, clipped to SAT_LIM; evaluated on constants only
	function automatic logic [VAL_W:0] mult_sat(input int unsigned k, input int unsigned n);
		longint unsigned p;
		p = longint'(k);
		for (int unsigned i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		if (p > SAT_LIM) begin
			return '1;
		end
		return p[VAL_W:0];
	endfunction

endpackage

// ===== rtl/danf_front.sv =====
module danf_front #(
	parameter int unsigned INT_DIGITS  = danf_pkg::INT_DIGITS_DEF,
	parameter int unsigned FRAC_DIGITS = danf_pkg::FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                num_valid,
	output logic                num_ready,
	input  danf_pkg::num_item_t num,
	output logic                task_valid,
	input  logic                task_ready,
	output danf_pkg::task_t     task_out
);
	import danf_pkg::*;

	localparam logic [VAL_W:0] IMAX = mult_sat(1, INT_DIGITS) - 1'b1;
	localparam logic [VAL_W:0] FMAX = mult_sat(1, FRAC_DIGITS) - 1'b1;

	logic  valid_s1;
	task_t task_s1;
	task_t task_d;

	// Saturate, count integer digits, flag a nonzero fraction
	always_comb begin
		task_d.int_val  = num.int_part;
		task_d.frac_val = num.frac_millis;
		if ({1'b0, num.int_part} > IMAX) begin
			task_d.int_val = IMAX[VAL_W-1:0];
		end
		if ({{(VAL_W + 1 - FRAC_W){1'b0}}, num.frac_millis} > FMAX) begin
			task_d.frac_val = FMAX[FRAC_W-1:0];
		end
		task_d.n_int = DIG_CNT_W'(1);
		for (int unsigned i = 1; i < INT_DIGITS; i++) begin
			if ({1'b0, num.int_part} >= mult_sat(1, i)) begin
				task_d.n_int = task_d.n_int + DIG_CNT_W'(1);
			end
		end
		task_d.has_frac = (num.frac_millis != '0);
	end

	assign num_ready  = !valid_s1 || task_ready;
	assign task_valid = valid_s1;
	assign task_out   = task_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (num_ready) begin
			valid_s1 <= num_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (num_ready && num_valid) begin
			task_s1 <= task_d;
		end
	end

endmodule

// ===== rtl/danf_queue.sv =====
module danf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  danf_pkg::task_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output danf_pkg::task_t pop_data
);
	import danf_pkg::*;

	localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	task_t            mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W + 1)'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/danf_back.sv =====
module danf_back #(
	parameter int unsigned FRAC_DIGITS = danf_pkg::FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                task_valid,
	input  danf_pkg::task_t     task_in,
	output logic                pop,
	output logic                chr_valid,
	input  logic                chr_ready,
	output danf_pkg::chr_item_t chr
);
	import danf_pkg::*;

	typedef enum logic [2:0] {
		PH_INT  = 3'b001,
		PH_DOT  = 3'b010,
		PH_FRAC = 3'b100
	} phase_t;

	logic                 busy_q;
	phase_t               phase_q;
	logic [VAL_W-1:0]     int_q;
	logic [FRAC_W-1:0]    frac_q;
	logic [DIG_CNT_W-1:0] idx_q;
	logic                 has_frac_q;
	logic                 out_valid_q;
	chr_item_t            out_q;

	logic [VAL_W:0]       thr [1:9];
	logic [VAL_W:0]       opnd;
	logic [VAL_W:0]       sel;
	logic [VAL_W:0]       rem;
	logic [3:0]           digit;
	logic                 advance;
	logic                 last_char;
	chr_item_t            chr_d;

	// Thresholds k * 10^idx for the current digit place
	always_comb begin
		for (int unsigned k = 1; k <= 9; k++) begin
			thr[k] = '1;
		end
		for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
			if (idx_q == DIG_CNT_W'(i)) begin
				for (int unsigned k = 1; k <= 9; k++) begin
					thr[k] = mult_sat(k, i);
				end
			end
		end
	end

	// One decimal digit per cycle from the remaining value, while the output is not stalled
	always_comb begin
		opnd = (phase_q == PH_FRAC) ? {{(VAL_W + 1 - FRAC_W){1'b0}}, frac_q} : {1'b0, int_q};
		digit = '0;
		for (int unsigned k = 1; k <= 9; k++) begin
			if (opnd >= thr[k]) begin
				digit = digit + 4'd1;
			end
		end
		sel = '0;
		for (int unsigned k = 1; k <= 9; k++) begin
			if (digit == 4'(k)) begin
				sel = thr[k];
			end
		end
		rem = opnd - sel;
	end

	always_comb begin
		last_char = 1'b0;
		chr_d.char_code = ASCII_ZERO + {4'd0, digit};
		unique case (phase_q)
			PH_INT: begin
				last_char = (idx_q == '0) && !has_frac_q;
			end
			PH_DOT: begin
				chr_d.char_code = ASCII_DOT;
			end
			PH_FRAC: begin
				last_char = (idx_q == '0);
			end
			default: begin
				last_char = 1'b0;
			end
		endcase
		chr_d.is_last = last_char;
	end

	assign advance   = !out_valid_q || chr_ready;
	assign pop       = task_valid && (!busy_q || (advance && last_char));
	assign chr_valid = out_valid_q;
	assign chr       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_INT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q  <= 1'b1;
				phase_q <= PH_INT;
			end else if (busy_q && advance) begin
				if (last_char) begin
					busy_q <= 1'b0;
				end else begin
					unique case (phase_q)
						PH_INT: begin
							if (idx_q == '0) begin
								phase_q <= PH_DOT;
							end
						end
						PH_DOT: begin
							phase_q <= PH_FRAC;
						end
						PH_FRAC: begin
							phase_q <= PH_FRAC;
						end
						default: begin
							phase_q <= PH_INT;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && advance) begin
			out_q <= chr_d;
		end
		if (pop) begin
			int_q      <= task_in.int_val;
			frac_q     <= task_in.frac_val;
			idx_q      <= task_in.n_int - DIG_CNT_W'(1);
			has_frac_q <= task_in.has_frac;
		end else if (busy_q && advance) begin
			unique case (phase_q)
				PH_INT: begin
					int_q <= rem[VAL_W-1:0];
					idx_q <= idx_q - 1'b1;
				end
				PH_DOT: begin
					idx_q <= DIG_CNT_W'(FRAC_DIGITS - 1);
				end
				PH_FRAC: begin
					frac_q <= rem[FRAC_W-1:0];
					idx_q  <= idx_q - 1'b1;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/decimal_ascii_number_formatter.sv =====
// Path: front register, queue, then the back end with its single digit extractor.
// Throughput: one character per cycle while chr_ready is high; a number gives 1 to
// INT_DIGITS + 1 + FRAC_DIGITS characters (9 at the defaults).
// The front end classifies the next number while the back end is still emitting.
// Reset: asynchronous, active low; clears handshake, queue and sequencer control.
module decimal_ascii_number_formatter #(
	parameter int unsigned INT_DIGITS  = danf_pkg::INT_DIGITS_DEF,
	parameter int unsigned FRAC_DIGITS = danf_pkg::FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                num_valid,
	output logic                num_ready,
	input  danf_pkg::num_item_t num,
	output logic                chr_valid,
	input  logic                chr_ready,
	output danf_pkg::chr_item_t chr
);
	import danf_pkg::*;

	// Front to queue
	logic  f_valid;
	task_t f_task;
	logic  q_full;
	logic  q_push;

	// Queue to back
	logic  q_not_empty;
	logic  q_pop;
	task_t q_task;

	assign q_push = f_valid && !q_full;

	// Front: take a number, saturate both parts, count integer digits
	danf_front #(
		.INT_DIGITS (INT_DIGITS),
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num       (num),
		.task_valid(f_valid),
		.task_ready(!q_full),
		.task_out  (f_task)
	);

	// Short queue: decouple front stalls from the character stream
	danf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(f_task),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_data (q_task)
	);

	// Back: walk the digits, insert the point, mark the last character
	danf_back #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_valid(q_not_empty),
		.task_in   (q_task),
		.pop       (q_pop),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr)
	);

	// Never write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("queue popped while empty");

	// A taken character that is not the last is followed at once by the next one
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(chr_valid && chr_ready && !chr.is_last) |=> chr_valid)
		else $error("gap inside a number");

endmodule
